>>> rtl/tftp_transfer_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// TFTP transfer sequencer assertion macros
// Shared concurrent assertion macros, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TFTP_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define TFTP_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TTS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tts assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TTS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tts assertion failed");

`else

`define TTS_ASSERT_NOW(name, ante, cons)
`define TTS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer package
// Types, event and action codes and size constants shared by the sequencer.
// ----------------------------------------------------------------------------
package tts_pkg;

    // Payload bytes of a full data block.
    localparam int unsigned BLOCK_BYTES = 512;

    // Full block size in the widths used by the compares.
    localparam logic [10:0] BLOCK_LEN_W  = 11'(BLOCK_BYTES);
    localparam logic [9:0]  BLOCK_LEN    = 10'(BLOCK_BYTES);
    localparam logic [11:0] FULL_DGRAM   = 12'(BLOCK_BYTES + 4);

    // Event kinds.
    localparam logic [1:0] FN_START   = 2'd0;
    localparam logic [1:0] FN_PACKET  = 2'd1;
    localparam logic [1:0] FN_TIMEOUT = 2'd2;

    // Actions.
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_DATA   = 3'd1;
    localparam logic [2:0] ACT_ACK    = 3'd2;
    localparam logic [2:0] ACT_RESEND = 3'd3;
    localparam logic [2:0] ACT_ABORT  = 3'd4;

    // Opcode of a DATA packet.
    localparam logic [7:0] OPC_DATA = 8'h03;

    // Configuration register indexes and reset values.
    localparam logic REG_DIRECTION     = 1'b0;
    localparam logic REG_TIMEOUT_LIMIT = 1'b1;
    localparam logic [3:0] TIMEOUT_LIMIT_RESET = 4'd10;
    localparam logic [3:0] RETRY_MAX = 4'd15;

    typedef struct packed {
        logic       direction;
        logic [3:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  pkt_opcode;
        logic [15:0] pkt_block;
        logic [10:0] pkt_length;
        logic [9:0]  chunk_length;
    } event_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] out_block;
        logic [9:0]  out_length;
        logic        store_payload;
        logic        transfer_done;
    } result_t;

endpackage

>>> rtl/tts_cfg_regs.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer configuration registers
// APB-style register file holding the transfer direction and retry limit.
// ----------------------------------------------------------------------------
module tts_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output tts_pkg::cfg_t cfg
);
    import tts_pkg::*;

    logic       direction_reg;
    logic [3:0] timeout_limit_reg;
    logic       wr_en;

    // A write lands in the access phase; the port never stalls.
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg     <= 1'b0;
            timeout_limit_reg <= TIMEOUT_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_DIRECTION)
            begin
                direction_reg <= pwdata[0];
            end
            else
            begin
                timeout_limit_reg <= pwdata[3:0];
            end
        end
    end

    // Read data.
    always_comb
    begin
        case (paddr[2])
            REG_DIRECTION:     prdata = {31'd0, direction_reg};
            REG_TIMEOUT_LIMIT: prdata = {28'd0, timeout_limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.direction     = direction_reg;
    assign cfg.timeout_limit = timeout_limit_reg;

endmodule

>>> rtl/tts_engine.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer engine
// Transfer state and the per-event decision logic for send and receive mode.
// ----------------------------------------------------------------------------
`include "tftp_transfer_sequencer_unit_assert.svh"

module tts_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  tts_pkg::cfg_t    cfg,
    input  tts_pkg::event_t  evt,
    output tts_pkg::result_t res
);
    import tts_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ACTIVE,
        PH_DONE,
        PH_ABORT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] next_block_reg, next_block_next;
    logic [15:0] sent_block_reg, sent_block_next;
    logic [9:0]  last_size_reg, last_size_next;
    logic [15:0] accepted_block_reg, accepted_block_next;
    logic [3:0]  retry_count_reg, retry_count_next;

    logic [9:0]  chunk_size;
    logic        short_blk;
    logic        dgram_short;
    logic [3:0]  retry_inc;

    // Data size saturates at a full block.
    assign chunk_size  = ({1'b0, evt.chunk_length} > BLOCK_LEN_W) ? BLOCK_LEN
                                                                : evt.chunk_length;
    assign short_blk   = {1'b0, last_size_reg} < BLOCK_LEN_W;
    assign dgram_short = {1'b0, evt.pkt_length} < FULL_DGRAM;
    assign retry_inc   = (retry_count_reg == RETRY_MAX) ? RETRY_MAX
                                                        : retry_count_reg + 4'd1;

    // Decision logic for one event.
    always_comb
    begin
        phase_next          = phase_reg;
        next_block_next     = next_block_reg;
        sent_block_next     = sent_block_reg;
        last_size_next      = last_size_reg;
        accepted_block_next = accepted_block_reg;
        retry_count_next    = retry_count_reg;
        res                 = '0;
        res.action          = ACT_NONE;

        case (evt.func)
            FN_START:
            begin
                phase_next          = PH_ACTIVE;
                retry_count_next    = 4'd0;
                accepted_block_next = 16'd0;
                if (!cfg.direction)
                begin
                    sent_block_next = 16'd1;
                    next_block_next = 16'd2;
                    last_size_next  = chunk_size;
                    res.action      = ACT_DATA;
                    res.out_block   = 16'd1;
                    res.out_length  = chunk_size;
                end
                else
                begin
                    sent_block_next = 16'd0;
                    next_block_next = 16'd1;
                    last_size_next  = 10'd0;
                    res.action      = ACT_ACK;
                end
            end

            FN_PACKET:
            begin
                if (phase_reg == PH_ACTIVE)
                begin
                    retry_count_next = 4'd0;
                    if (!cfg.direction)
                    begin
                        // Send mode: the ack after a short block ends the transfer.
                        if (short_blk)
                        begin
                            phase_next        = PH_DONE;
                            res.transfer_done = 1'b1;
                        end
                        else if (evt.pkt_block == sent_block_reg)
                        begin
                            sent_block_next = next_block_reg;
                            next_block_next = next_block_reg + 16'd1;
                            last_size_next  = chunk_size;
                            res.action      = ACT_DATA;
                            res.out_block   = next_block_reg;
                            res.out_length  = chunk_size;
                        end
                    end
                    else if (evt.pkt_opcode == OPC_DATA &&
                             evt.pkt_block > accepted_block_reg)
                    begin
                        // Receive mode: only newer data blocks are taken.
                        accepted_block_next = evt.pkt_block;
                        res.action          = ACT_ACK;
                        res.out_block       = evt.pkt_block;
                        res.store_payload   = 1'b1;
                        if (dgram_short)
                        begin
                            phase_next        = PH_DONE;
                            res.transfer_done = 1'b1;
                        end
                    end
                end
            end

            FN_TIMEOUT:
            begin
                if (phase_reg == PH_ACTIVE)
                begin
                    retry_count_next = retry_inc;
                    if (retry_inc >= cfg.timeout_limit)
                    begin
                        phase_next = PH_ABORT;
                        res.action = ACT_ABORT;
                    end
                    else if (!cfg.direction)
                    begin
                        res.action     = ACT_RESEND;
                        res.out_block  = sent_block_reg;
                        res.out_length = last_size_reg;
                        if (short_blk)
                        begin
                            phase_next        = PH_DONE;
                            res.transfer_done = 1'b1;
                        end
                    end
                    else
                    begin
                        res.action    = ACT_RESEND;
                        res.out_block = accepted_block_reg;
                    end
                end
            end

            default:
            begin
                res.action = ACT_NONE;
            end
        endcase
    end

    // Transfer state, updated once per processed event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            next_block_reg     <= 16'd1;
            sent_block_reg     <= 16'd0;
            last_size_reg      <= 10'd0;
            accepted_block_reg <= 16'd0;
            retry_count_reg    <= 4'd0;
        end
        else if (fire)
        begin
            phase_reg          <= phase_next;
            next_block_reg     <= next_block_next;
            sent_block_reg     <= sent_block_next;
            last_size_reg      <= last_size_next;
            accepted_block_reg <= accepted_block_next;
            retry_count_reg    <= retry_count_next;
        end
    end

    // An abort leaves the transfer in the aborted phase.
    `TTS_ASSERT_NEXT(a_abort_phase, fire && res.action == ACT_ABORT, phase_reg == PH_ABORT)
    // A normal finish leaves the transfer in the done phase.
    `TTS_ASSERT_NEXT(a_done_phase, fire && res.transfer_done, phase_reg == PH_DONE)
    // A start always activates the transfer with a fresh retry count.
    `TTS_ASSERT_NEXT(a_start_fresh, fire && evt.func == FN_START,
                     phase_reg == PH_ACTIVE && retry_count_reg == 4'd0)

endmodule

>>> rtl/tftp_transfer_sequencer_unit.sv
// ----------------------------------------------------------------------------
// TFTP transfer sequencer unit
// Lock-step TFTP block sequencer with request and result registers.
// ----------------------------------------------------------------------------
// Each request (start, received packet or timeout) yields exactly one result
// naming the action to take. A request is registered on acceptance, decided
// against the transfer state once the result register is free, and its result
// is held in an output register until taken. One request can be accepted every
// cycle, limited only by the result side taking results. The user must write
// the direction and retry limit registers over the APB port only while no
// request is in flight; the block itself does not enforce this.
`include "tftp_transfer_sequencer_unit_assert.svh"

module tftp_transfer_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  pkt_opcode,
    input  logic [15:0] pkt_block,
    input  logic [10:0] pkt_length,
    input  logic [9:0]  chunk_length,
    // Result channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [15:0] out_block,
    output logic [9:0]  out_length,
    output logic        store_payload,
    output logic        transfer_done
);
    import tts_pkg::*;

    cfg_t    cfg;
    event_t  evt_reg;
    result_t res;
    result_t result_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    fire;

    // Handshake: the request register drains whenever the result slot frees.
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    tts_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tts_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cfg   (cfg),
        .evt   (evt_reg),
        .res   (res)
    );

    // Valid flags of the request and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            evt_reg.func         <= func;
            evt_reg.pkt_opcode   <= pkt_opcode;
            evt_reg.pkt_block    <= pkt_block;
            evt_reg.pkt_length   <= pkt_length;
            evt_reg.chunk_length <= chunk_length;
        end
        if (fire)
        begin
            result_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = result_reg.action;
    assign out_block     = result_reg.out_block;
    assign out_length    = result_reg.out_length;
    assign store_payload = result_reg.store_payload;
    assign transfer_done = result_reg.transfer_done;

    // A full pipeline with a stalled result side takes no new request.
    `TTS_ASSERT_NOW(a_stall_blocks, in_valid_reg && out_valid_reg && !out_ready, !in_ready)
    // A processed request always shows up as a result in the next cycle.
    `TTS_ASSERT_NEXT(a_fire_result, fire, out_valid_reg)
    // Payload is only stored together with an acknowledgement.
    `TTS_ASSERT_NOW(a_store_ack, out_valid_reg && store_payload, action == ACT_ACK)

endmodule
